/* hw/rtl/lfu_cache_table_top_macros.svh */
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_TOP_MACROS_SVH
`define LFU_CACHE_TABLE_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LFU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lfuc_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache table package
// Sizes, types and codes shared by the slot store, scan unit and top level.
// ----------------------------------------------------------------------------
package lfuc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 16;
	localparam int FIELD_BITS = 32;
	localparam int CAP_BITS   = 5;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int HELD_BITS  = $clog2(ENTRIES + 1);
	localparam int CMP_BITS   = (CAP_BITS > HELD_BITS) ? CAP_BITS : HELD_BITS;

	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [IDX_BITS-1:0]   rank_t;
	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [HELD_BITS-1:0]  held_t;
	typedef logic [CAP_BITS-1:0]   cap_t;
	typedef logic [CMP_BITS-1:0]   cmp_t;
	typedef logic [FIELD_BITS-1:0] field_t;

	localparam count_t COUNT_MAX   = '1;
	localparam count_t COUNT_FIRST = count_t'(1);
	localparam idx_t   LAST_IDX    = idx_t'(ENTRIES - 1);
	localparam cap_t   CAP_RESET   = cap_t'(16);
	localparam cmp_t   CAP_LIMIT   = cmp_t'(ENTRIES);

	typedef enum logic {
		KIND_GET = 1'b0,
		KIND_PUT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	// One slot as seen through the store's read port.
	typedef struct packed {
		logic   valid;
		key_t   key;
		value_t value;
		count_t count;
		rank_t  rank;
	} slot_view_t;

	// What a full scan found.
	typedef struct packed {
		logic   match;
		idx_t   match_idx;
		value_t match_value;
		count_t match_count;
		rank_t  match_rank;
		logic   vic_ok;
		idx_t   vic_idx;
		key_t   vic_key;
		rank_t  vic_rank;
		logic   free_ok;
		idx_t   free_idx;
	} scan_res_t;

	// Changes applied to the store together, in the same cycle.
	typedef struct packed {
		logic   touch;
		idx_t   touch_idx;
		rank_t  touch_rank;
		count_t touch_count;
		logic   set_val;
		logic   drop;
		idx_t   drop_idx;
		rank_t  drop_rank;
		logic   ins;
		idx_t   ins_idx;
		key_t   key;
		value_t value;
	} slot_upd_t;

	// One result item.
	typedef struct packed {
		logic   hit;
		field_t read_value;
		logic   evicted;
		field_t evicted_key;
	} result_t;

endpackage

/* hw/rtl/lfuc_slots.sv */
// ----------------------------------------------------------------------------
// LFU cache slot store
// Slot arrays with one indexed read port and a per-slot update of ranks.
// ----------------------------------------------------------------------------
`include "lfu_cache_table_top_macros.svh"

module lfuc_slots (
	input  logic                clk,
	input  logic                arst_n,
	input  lfuc_pkg::idx_t      rd_idx,
	output lfuc_pkg::slot_view_t view,
	input  lfuc_pkg::slot_upd_t upd,
	output lfuc_pkg::held_t     held
);

	logic [lfuc_pkg::ENTRIES-1:0] valid_q;
	lfuc_pkg::key_t   key_q   [lfuc_pkg::ENTRIES];
	lfuc_pkg::value_t value_q [lfuc_pkg::ENTRIES];
	lfuc_pkg::count_t count_q [lfuc_pkg::ENTRIES];
	lfuc_pkg::rank_t  rank_q  [lfuc_pkg::ENTRIES];
	lfuc_pkg::held_t  held_q;

	// Read port used by the scan.
	always_comb begin
		view.valid = valid_q[rd_idx];
		view.key   = key_q[rd_idx];
		view.value = value_q[rd_idx];
		view.count = count_q[rd_idx];
		view.rank  = rank_q[rd_idx];
	end

	assign held = held_q;

	// Valid bits: a drop clears, an insert sets; an insert may reuse the dropped slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < lfuc_pkg::ENTRIES; i++) begin
				if (upd.ins && lfuc_pkg::idx_t'(i) == upd.ins_idx) begin
					valid_q[i] <= 1'b1;
				end else if (upd.drop && lfuc_pkg::idx_t'(i) == upd.drop_idx) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// Number of slots held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			case ({upd.drop, upd.ins})
				2'b10: held_q <= held_q - 1'b1;
				2'b01: held_q <= held_q + 1'b1;
				default: held_q <= held_q;
			endcase
		end
	end

	// Slot payload and recency ranks.
	always_ff @(posedge clk) begin
		for (int i = 0; i < lfuc_pkg::ENTRIES; i++) begin
			if (upd.touch) begin
				if (lfuc_pkg::idx_t'(i) == upd.touch_idx) begin
					rank_q[i]  <= '0;
					count_q[i] <= upd.touch_count;
					if (upd.set_val) begin
						value_q[i] <= upd.value;
					end
				end else if (valid_q[i] && rank_q[i] < upd.touch_rank) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (upd.ins) begin
				if (lfuc_pkg::idx_t'(i) == upd.ins_idx) begin
					rank_q[i]  <= '0;
					count_q[i] <= lfuc_pkg::COUNT_FIRST;
					key_q[i]   <= upd.key;
					value_q[i] <= upd.value;
				end else if (valid_q[i] &&
					!(upd.drop && lfuc_pkg::idx_t'(i) == upd.drop_idx)) begin
					// Other valid entries age by one, unless they ranked older than the dropped one.
					if (!(upd.drop && rank_q[i] > upd.drop_rank)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
		end
	end

	`LFU_ASSERT_SAME(a_held_matches_valid, 1'b1, $countones(valid_q) == held_q,
		"held count differs from the number of valid slots")
	`LFU_ASSERT_SAME(a_no_insert_when_full, upd.ins && !upd.drop,
		held_q < lfuc_pkg::held_t'(lfuc_pkg::ENTRIES), "insert into a full store")

endmodule

/* hw/rtl/lfuc_scan.sv */
// ----------------------------------------------------------------------------
// LFU cache scan unit
// Looks at one slot per cycle while step is high: key match, victim choice and first free slot.
// ----------------------------------------------------------------------------
module lfuc_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 step,
	input  lfuc_pkg::key_t       find_key,
	input  lfuc_pkg::idx_t       view_idx,
	input  lfuc_pkg::slot_view_t view,
	output lfuc_pkg::scan_res_t  res
);

	logic             match_q;
	lfuc_pkg::idx_t   match_idx_q;
	lfuc_pkg::value_t match_value_q;
	lfuc_pkg::count_t match_count_q;
	lfuc_pkg::rank_t  match_rank_q;
	logic             vic_ok_q;
	lfuc_pkg::idx_t   vic_idx_q;
	lfuc_pkg::key_t   vic_key_q;
	lfuc_pkg::count_t vic_count_q;
	lfuc_pkg::rank_t  vic_rank_q;
	logic             free_ok_q;
	lfuc_pkg::idx_t   free_idx_q;

	logic hit_now;
	logic vic_better;
	logic free_now;

	// Shared compare step for the slot under the index.
	always_comb begin
		hit_now    = view.valid && view.key == find_key;
		vic_better = view.valid && (!vic_ok_q || view.count < vic_count_q ||
			(view.count == vic_count_q && view.rank > vic_rank_q));
		free_now   = !view.valid && !free_ok_q;
	end

	// Found flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q   <= 1'b0;
			vic_ok_q  <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (clear) begin
			match_q   <= 1'b0;
			vic_ok_q  <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (step) begin
			if (hit_now) begin
				match_q <= 1'b1;
			end
			if (vic_better) begin
				vic_ok_q <= 1'b1;
			end
			if (free_now) begin
				free_ok_q <= 1'b1;
			end
		end
	end

	// Captured slot data.
	always_ff @(posedge clk) begin
		if (step && !clear) begin
			if (hit_now) begin
				match_idx_q   <= view_idx;
				match_value_q <= view.value;
				match_count_q <= view.count;
				match_rank_q  <= view.rank;
			end
			if (vic_better) begin
				vic_idx_q   <= view_idx;
				vic_key_q   <= view.key;
				vic_count_q <= view.count;
				vic_rank_q  <= view.rank;
			end
			if (free_now) begin
				free_idx_q <= view_idx;
			end
		end
	end

	always_comb begin
		res.match       = match_q;
		res.match_idx   = match_idx_q;
		res.match_value = match_value_q;
		res.match_count = match_count_q;
		res.match_rank  = match_rank_q;
		res.vic_ok      = vic_ok_q;
		res.vic_idx     = vic_idx_q;
		res.vic_key     = vic_key_q;
		res.vic_rank    = vic_rank_q;
		res.free_ok     = free_ok_q;
		res.free_idx    = free_idx_q;
	end

endmodule

/* hw/rtl/lfu_cache_table_top.sv */
// ----------------------------------------------------------------------------
// LFU cache table top level
// A get/put item arrives on the s_ channel; one result item leaves on m_.
// Each item is checked against all slots, one slot per cycle, by a single
// compare unit. On a get hit the entry's count rises and it becomes most
// recent; with a nonzero capacity a put updates or inserts, evicting the
// least used, least recent entry when the configured capacity is reached.
// The scan visits every slot in turn; the apply state then writes the store
// update and loads the result into the output register. The sequencer then
// returns to idle, and only then can the next item be taken.
// s_tready is high only while the sequencer is idle. If the receiver stalls,
// the result waits in the output register; a new item can still be taken,
// and it holds in its apply cycle until that register is free.
// cfg_wr_en writes the capacity; write it only while no item is in flight.
// Reset empties the cache and sets the capacity to sixteen entries.
// ----------------------------------------------------------------------------
`include "lfu_cache_table_top_macros.svh"

module lfu_cache_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,     // lookup_key[31:0], write_value[63:32]
	input  logic [0:0]  s_tuser,     // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,     // read_value[31:0], evicted_key[63:32]
	output logic [1:0]  m_tuser,     // hit[0], evicted[1]
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data  // capacity_in_use
);

	lfuc_pkg::state_t     state_q;
	lfuc_pkg::state_t     state_d;
	lfuc_pkg::idx_t       scan_idx_q;
	lfuc_pkg::cap_t       cfg_cap_q;
	lfuc_pkg::cmp_t       cap_q;
	lfuc_pkg::kind_t      kind_q;
	lfuc_pkg::key_t       key_q;
	lfuc_pkg::value_t     value_q;
	lfuc_pkg::result_t    out_q;
	lfuc_pkg::result_t    result;
	logic                 out_valid_q;
	logic                 clear;
	logic                 step;
	logic                 apply_fire;
	lfuc_pkg::slot_view_t view;
	lfuc_pkg::scan_res_t  res;
	lfuc_pkg::slot_upd_t  upd;
	lfuc_pkg::held_t      held;
	lfuc_pkg::cmp_t       cap_in;
	logic                 is_put;
	logic                 cap_on;
	logic                 evict;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cap_q <= lfuc_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cfg_cap_q <= cfg_wr_data;
		end
	end

	// Capacity above the slot count acts as the slot count.
	always_comb begin
		cap_in = lfuc_pkg::cmp_t'(cfg_cap_q);
		if (cap_in > lfuc_pkg::CAP_LIMIT) begin
			cap_in = lfuc_pkg::CAP_LIMIT;
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfuc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and strobes.
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		clear      = 1'b0;
		step       = 1'b0;
		apply_fire = 1'b0;
		case (state_q)
			lfuc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					clear   = 1'b1;
					state_d = lfuc_pkg::ST_SCAN;
				end
			end
			lfuc_pkg::ST_SCAN: begin
				step = 1'b1;
				if (scan_idx_q == lfuc_pkg::LAST_IDX) begin
					state_d = lfuc_pkg::ST_APPLY;
				end
			end
			lfuc_pkg::ST_APPLY: begin
				if (!out_valid_q || m_tready) begin
					apply_fire = 1'b1;
					state_d    = lfuc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfuc_pkg::ST_IDLE;
			end
		endcase
	end

	// Scan index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
		end else if (clear) begin
			scan_idx_q <= '0;
		end else if (step) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (clear) begin
			kind_q  <= lfuc_pkg::kind_t'(s_tuser[0]);
			key_q   <= lfuc_pkg::key_t'(s_tdata[31:0]);
			value_q <= lfuc_pkg::value_t'(s_tdata[63:32]);
			cap_q   <= cap_in;
		end
	end

	lfuc_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (scan_idx_q),
		.view   (view),
		.upd    (upd),
		.held   (held)
	);

	lfuc_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.step     (step),
		.find_key (key_q),
		.view_idx (scan_idx_q),
		.view     (view),
		.res      (res)
	);

	// Store update and result from the finished scan.
	always_comb begin
		is_put = kind_q == lfuc_pkg::KIND_PUT;
		cap_on = cap_q != '0;
		evict  = is_put && cap_on && !res.match && res.vic_ok &&
			lfuc_pkg::cmp_t'(held) >= cap_q;

		upd.touch       = apply_fire && res.match && (!is_put || cap_on);
		upd.touch_idx   = res.match_idx;
		upd.touch_rank  = res.match_rank;
		upd.touch_count = (res.match_count == lfuc_pkg::COUNT_MAX) ?
			res.match_count : res.match_count + 1'b1;
		upd.set_val     = res.match && is_put && cap_on;
		upd.drop        = apply_fire && evict;
		upd.drop_idx    = res.vic_idx;
		upd.drop_rank   = res.vic_rank;
		upd.ins         = apply_fire && is_put && cap_on && !res.match &&
			(evict || res.free_ok);
		// Lowest free slot once the victim is gone.
		if (evict && !(res.free_ok && res.free_idx < res.vic_idx)) begin
			upd.ins_idx = res.vic_idx;
		end else begin
			upd.ins_idx = res.free_idx;
		end
		upd.key   = key_q;
		upd.value = value_q;

		result.hit         = res.match;
		result.read_value  = (!is_put && res.match) ?
			lfuc_pkg::field_t'(res.match_value) : '0;
		result.evicted     = evict;
		result.evicted_key = evict ? lfuc_pkg::field_t'(res.vic_key) : '0;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.evicted_key, out_q.read_value};
	assign m_tuser  = {out_q.evicted, out_q.hit};

	`LFU_ASSERT_NEXT(a_accept_starts_scan, s_tvalid && s_tready,
		state_q == lfuc_pkg::ST_SCAN && scan_idx_q == '0, "accepted item did not start a scan")
	`LFU_ASSERT_SAME(a_evict_only_on_miss, out_valid_q && out_q.evicted, !out_q.hit,
		"eviction reported on a hit")
	`LFU_ASSERT_SAME(a_apply_after_full_scan, apply_fire,
		scan_idx_q == '0 && state_q == lfuc_pkg::ST_APPLY, "update applied before the scan ended")

endmodule
